@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers for the 3x3 clamped box smoothing block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    // image geometry
    localparam int MAX_DIM = 1024;
    localparam int COL_W   = $clog2(MAX_DIM);
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIM);

    // pixel arithmetic
    localparam int NCH      = 3;
    localparam int CH_W     = 16;
    localparam int COLSUM_W = CH_W + 1;   // two pixels of one column
    localparam int SUM_W    = CH_W + 4;   // up to nine pixels

    // reciprocal division: q = (x * m) >> RECIP_SHIFT, exact for x < 2**SUM_W
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(4194304);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(2796203);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(1864136);

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = FIFO_AW + 1;

    // configuration port
    localparam int APB_AW = 3;
    localparam logic REG_IMAGE_SIZE = 1'b0;   // register index, paddr[APB_AW-1]

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIV4 = 2'd0,
        DIV6 = 2'd1,
        DIV9 = 2'd2
    } div_t;

    typedef logic [NCH-1:0][CH_W-1:0]     pix_t;
    typedef logic [NCH-1:0][COLSUM_W-1:0] colsum_t;
    typedef logic [NCH-1:0][SUM_W-1:0]    sum_t;

    // accepted item with its position, as seen by the summing stage
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [COL_W-1:0] col;
        logic             row_ge1;
        logic             row_ge2;
        logic             col_ge1;
        logic             col_ge2;
        logic             col_last;
        logic             row_last;
        pix_t             pix;
    } s1_t;

    // one pending result before division
    typedef struct packed {
        logic valid;
        sum_t sum;
        div_t div;
        logic last;
    } lane_t;

    // one finished result
    typedef struct packed {
        logic last;
        pix_t pix;
    } res_t;

    function automatic logic [RECIP_W-1:0] div_recip(input div_t d);
        logic [RECIP_W-1:0] m;
        case (d)
            DIV4:    m = RECIP_4;
            DIV6:    m = RECIP_6;
            DIV9:    m = RECIP_9;
            default: m = RECIP_4;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsc_ctrl
// Register port, row/column/drain counters, input acceptance and input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ctrl
    import bsc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [NCH*CH_W-1:0] s_tdata,
    input  wire logic                s_tuser,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    input  wire logic [LVL_W-1:0]    fifo_level,
    input  wire logic                s2_busy,
    output s1_t                      s1,
    output logic [COL_W-1:0]         rd_addr
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [COL_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  drn_reg, drn_next;
    logic              drain_reg, drain_next;
    s1_t               s1_reg, s1_next;

    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] n_eff_m1;
    logic [COL_W-1:0]  last_idx;
    logic              cfg_wr;
    logic              accept;
    logic [LVL_W:0]    credit;
    op_t               op;

    // saturate the image size to the supported range
    always_comb begin
        if (size_reg < SIZE_MIN) begin
            n_eff = SIZE_MIN;
        end else if (size_reg > SIZE_MAX) begin
            n_eff = SIZE_MAX;
        end else begin
            n_eff = size_reg;
        end
    end

    assign n_eff_m1 = n_eff - SIZE_W'(1);
    assign last_idx = n_eff_m1[COL_W-1:0];

    // register access
    assign cfg_wr = psel & penable & pwrite & (paddr[APB_AW-1] == REG_IMAGE_SIZE);
    assign prdata = (paddr[APB_AW-1] == REG_IMAGE_SIZE) ? 32'(size_reg) : 32'd0;

    // accept only while the queue can take every result still in flight
    assign credit = (LVL_W+1)'(fifo_level)
                  + (s1_reg.valid ? (LVL_W+1)'(2) : (LVL_W+1)'(0))
                  + (s2_busy      ? (LVL_W+1)'(2) : (LVL_W+1)'(0));
    assign s_tready = (credit <= (LVL_W+1)'(FIFO_DEPTH - 2));
    assign accept   = s_tvalid & s_tready;
    assign op       = op_t'(s_tuser);

    // read ahead: row stores read the next beat's column, one past it in a drain
    assign rd_addr = drain_reg ? (drn_reg + COL_W'(1)) : col_reg;

    // advance counters and load the input stage
    always_comb begin
        size_next  = size_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        drn_next   = drn_reg;
        drain_next = drain_reg;
        s1_next          = s1_reg;
        s1_next.valid    = 1'b0;
        s1_next.op       = op;
        s1_next.pix      = s_tdata;
        s1_next.row_ge1  = 1'b0;
        s1_next.row_ge2  = 1'b0;
        s1_next.row_last = 1'b0;
        if (cfg_wr) begin
            size_next  = pwdata[SIZE_W-1:0];
            row_next   = '0;
            col_next   = '0;
            drn_next   = '0;
            drain_next = 1'b0;
        end else if (accept) begin
            if (op == OP_PUSH && !drain_reg) begin
                s1_next.valid    = 1'b1;
                s1_next.col      = col_reg;
                s1_next.row_ge1  = (row_reg != '0);
                s1_next.row_ge2  = (row_reg > COL_W'(1));
                s1_next.col_ge1  = (col_reg != '0);
                s1_next.col_ge2  = (col_reg > COL_W'(1));
                s1_next.col_last = (col_reg == last_idx);
                s1_next.row_last = (row_reg == last_idx);
                if (col_reg == last_idx) begin
                    col_next = '0;
                    if (row_reg == last_idx) begin
                        row_next   = '0;
                        drn_next   = '0;
                        drain_next = 1'b1;
                    end else begin
                        row_next = row_reg + COL_W'(1);
                    end
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end else if (op == OP_DRAIN && drain_reg) begin
                s1_next.valid    = 1'b1;
                s1_next.col      = drn_reg;
                s1_next.col_ge1  = (drn_reg != '0);
                s1_next.col_ge2  = (drn_reg > COL_W'(1));
                s1_next.col_last = (drn_reg == last_idx);
                if (drn_reg == last_idx) begin
                    drn_next   = '0;
                    drain_next = 1'b0;
                end else begin
                    drn_next = drn_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= SIZE_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            drn_reg   <= '0;
            drain_reg <= 1'b0;
            s1_reg    <= '0;
        end else begin
            size_reg  <= size_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drn_reg   <= drn_next;
            drain_reg <= drain_next;
            s1_reg    <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

@@ rtl/bsc_sum.sv @@
// ----------------------------------------------------------------------------
// bsc_sum
// Row stores, 3x3 window and drain window; forms the neighbourhood sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_sum
    import bsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire s1_t              s1,
    input  wire logic [COL_W-1:0] rd_addr,
    output lane_t                 lane_a,
    output lane_t                 lane_b,
    output logic                  s2_busy
);

    pix_t    upper_mem  [MAX_DIM];
    pix_t    middle_mem [MAX_DIM];
    pix_t    up_rd_reg;
    pix_t    md_rd_reg;
    pix_t    win_reg [6];
    colsum_t pre0_reg, pre1_reg;
    colsum_t dl_reg, dc_reg;
    lane_t   lane_a_reg, lane_a_next;
    lane_t   lane_b_reg, lane_b_next;

    logic    push_en;
    logic    drain_en;
    sum_t    s_cur, s_one, s_two;
    colsum_t col_here, col_mem, right, centre;
    sum_t    drain_sum;

    assign push_en  = s1.valid && (s1.op == OP_PUSH);
    assign drain_en = s1.valid && (s1.op == OP_DRAIN);

    // row stores: read ahead every cycle, shift the column down on a push
    always_ff @(posedge aclk) begin
        up_rd_reg <= upper_mem[rd_addr];
        if (push_en) begin
            upper_mem[s1.col] <= md_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        md_rd_reg <= middle_mem[rd_addr];
        if (push_en) begin
            middle_mem[s1.col] <= s1.pix;
        end
    end

    // per-channel column and window sums
    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            s_cur[j] = SUM_W'(md_rd_reg[j]) + SUM_W'(s1.pix[j])
                     + (s1.row_ge2 ? SUM_W'(up_rd_reg[j]) : SUM_W'(0));
            s_one[j] = SUM_W'(win_reg[1][j]) + SUM_W'(win_reg[2][j])
                     + (s1.row_ge2 ? SUM_W'(win_reg[0][j]) : SUM_W'(0));
            s_two[j] = SUM_W'(win_reg[4][j]) + SUM_W'(win_reg[5][j])
                     + (s1.row_ge2 ? SUM_W'(win_reg[3][j]) : SUM_W'(0));
            col_here[j] = COLSUM_W'(md_rd_reg[j]) + COLSUM_W'(s1.pix[j]);
            col_mem[j]  = COLSUM_W'(up_rd_reg[j]) + COLSUM_W'(md_rd_reg[j]);
        end
    end

    // drain window: first two columns come from the captured sums
    always_comb begin
        right  = s1.col_ge1 ? col_mem : pre1_reg;
        centre = s1.col_ge1 ? dc_reg  : pre0_reg;
        for (int j = 0; j < NCH; j++) begin
            drain_sum[j] = SUM_W'(centre[j])
                         + (s1.col_ge1   ? SUM_W'(dl_reg[j]) : SUM_W'(0))
                         + (!s1.col_last ? SUM_W'(right[j])  : SUM_W'(0));
        end
    end

    // build the one or two results of this beat
    always_comb begin
        lane_a_next = '0;
        lane_b_next = '0;
        if (push_en) begin
            lane_a_next.valid = s1.row_ge1 && s1.col_ge1;
            for (int j = 0; j < NCH; j++) begin
                lane_a_next.sum[j] = s_cur[j] + s_one[j]
                                   + (s1.col_ge2 ? s_two[j] : SUM_W'(0));
                lane_b_next.sum[j] = s_cur[j] + s_one[j];
            end
            if (s1.row_ge2) begin
                lane_a_next.div = s1.col_ge2 ? DIV9 : DIV6;
                lane_b_next.div = DIV6;
            end else begin
                lane_a_next.div = s1.col_ge2 ? DIV6 : DIV4;
                lane_b_next.div = DIV4;
            end
            lane_b_next.valid = s1.row_ge1 && s1.col_last;
        end else if (drain_en) begin
            lane_a_next.valid = 1'b1;
            lane_a_next.sum   = drain_sum;
            lane_a_next.div   = (s1.col_ge1 && !s1.col_last) ? DIV6 : DIV4;
            lane_a_next.last  = s1.col_last;
        end
    end

    // shift the window and capture the first two columns of the last row
    always_ff @(posedge aclk) begin
        if (push_en) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= up_rd_reg;
            win_reg[1] <= md_rd_reg;
            win_reg[2] <= s1.pix;
            if (s1.row_last && !s1.col_ge1) begin
                pre0_reg <= col_here;
            end
            if (s1.row_last && s1.col_ge1 && !s1.col_ge2) begin
                pre1_reg <= col_here;
            end
        end
        if (drain_en) begin
            dl_reg <= centre;
            dc_reg <= right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_a_reg <= '0;
            lane_b_reg <= '0;
        end else begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
        end
    end

    assign lane_a  = lane_a_reg;
    assign lane_b  = lane_b_reg;
    assign s2_busy = lane_a_reg.valid | lane_b_reg.valid;

endmodule

`default_nettype wire

@@ rtl/bsc_div.sv @@
// ----------------------------------------------------------------------------
// bsc_div
// Divides the neighbourhood sums by 4, 6 or 9 through reciprocal multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div
    import bsc_pkg::*;
(
    input  wire lane_t lane_a,
    input  wire lane_t lane_b,
    output res_t       res_a,
    output res_t       res_b,
    output logic       val_a,
    output logic       val_b
);

    logic [RECIP_W-1:0]          recip_a, recip_b;
    logic [NCH-1:0][PROD_W-1:0]  prod_a, prod_b;

    assign recip_a = div_recip(lane_a.div);
    assign recip_b = div_recip(lane_b.div);

    // multiply by the scaled reciprocal and keep the integer part
    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            prod_a[j] = PROD_W'(lane_a.sum[j]) * PROD_W'(recip_a);
            prod_b[j] = PROD_W'(lane_b.sum[j]) * PROD_W'(recip_b);
            res_a.pix[j] = prod_a[j][RECIP_SHIFT +: CH_W];
            res_b.pix[j] = prod_b[j][RECIP_SHIFT +: CH_W];
        end
        res_a.last = lane_a.last;
        res_b.last = lane_b.last;
    end

    assign val_a = lane_a.valid;
    assign val_b = lane_b.valid;

endmodule

`default_nettype wire

@@ rtl/bsc_fifo.sv @@
// ----------------------------------------------------------------------------
// bsc_fifo
// Output queue: takes up to two results per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_fifo
    import bsc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire res_t                res_a,
    input  wire logic                val_a,
    input  wire res_t                res_b,
    input  wire logic                val_b,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [NCH*CH_W-1:0]      m_tdata,
    output logic                     m_tlast,
    output logic [LVL_W-1:0]         level
);

    res_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [FIFO_AW-1:0] wr_ptr_b;
    logic [LVL_W-1:0]   n_push;
    logic               pop;

    assign m_tvalid = (level_reg != '0);
    assign pop      = m_tvalid & m_tready;
    assign n_push   = LVL_W'(val_a) + LVL_W'(val_b);
    assign wr_ptr_b = val_a ? (wr_ptr_reg + FIFO_AW'(1)) : wr_ptr_reg;

    // store the results in order, lane a first
    always_ff @(posedge aclk) begin
        if (val_a) begin
            fifo_mem[wr_ptr_reg] <= res_a;
        end
        if (val_b) begin
            fifo_mem[wr_ptr_b] <= res_b;
        end
    end

    // advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        level_next  = level_reg + n_push - LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign m_tdata = fifo_mem[rd_ptr_reg].pix;
    assign m_tlast = fifo_mem[rd_ptr_reg].last;
    assign level   = level_reg;

endmodule

`default_nettype wire

@@ rtl/box_smooth_3x3_clamped.sv @@
// ----------------------------------------------------------------------------
// box_smooth_3x3_clamped
// Streaming 3x3 box mean filter on a square RGB image, border-clipped.
// ----------------------------------------------------------------------------
// Pixels enter one beat per clock in raster order (s_tuser = 0) and each output
// beat carries the truncated per-channel mean over the pixel's 3x3 neighbourhood
// clipped to the image (4, 6 or 9 pixels). Output lags by one row and one pixel:
// the pixel at row r >= 1, column c >= 1 yields the result for (r-1, c-1), and
// the last pixel of a row also yields (r-1, N-1). After the last pixel, send N
// drain beats (s_tuser = 1), each giving one pixel of the final row; m_tlast
// marks the frame's last result and the block is then ready for the next frame.
// Drains while pixels are expected, and pixels during the drain, are consumed
// without a result. The block sustains one input beat per clock while s_tready
// is high; a result passes the input stage and the sum stage, then is divided
// into the eight-entry output queue, and s_tready drops only while that queue
// together with the results still in flight would leave no room for two more.
// The row stores are single-port-read RAMs read one column ahead and need
// no clearing after reset. Write image_size (address 0, 2..1024, reset 32) only
// while idle; a write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module box_smooth_3x3_clamped
    import bsc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input pixels
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // in_red[15:0], in_green[31:16], in_blue[47:32]
    input  wire logic              s_tuser,   // opcode: 0 push pixel, 1 drain
    // smoothed pixels
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,   // out_red[15:0], out_green[31:16], out_blue[47:32]
    output logic                   m_tlast,   // frame_end
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    s1_t              s1;
    logic [COL_W-1:0] rd_addr;
    lane_t            lane_a, lane_b;
    logic             s2_busy;
    res_t             res_a, res_b;
    logic             val_a, val_b;
    logic [LVL_W-1:0] fifo_level;

    assign pready = 1'b1;

    bsc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .fifo_level (fifo_level),
        .s2_busy    (s2_busy),
        .s1         (s1),
        .rd_addr    (rd_addr)
    );

    bsc_sum u_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s1      (s1),
        .rd_addr (rd_addr),
        .lane_a  (lane_a),
        .lane_b  (lane_b),
        .s2_busy (s2_busy)
    );

    bsc_div u_div (
        .lane_a (lane_a),
        .lane_b (lane_b),
        .res_a  (res_a),
        .res_b  (res_b),
        .val_a  (val_a),
        .val_b  (val_b)
    );

    bsc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_a    (res_a),
        .val_a    (val_a),
        .res_b    (res_b),
        .val_b    (val_b),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .level    (fifo_level)
    );

endmodule

`default_nettype wire

@@ rtl/bsc_checker.sv @@
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the box smoothing block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_checker
    import bsc_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [47:0]       m_tdata,
    input wire logic              m_tlast,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [APB_AW-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // reset empties the pipeline and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty and ready after reset");

    // the size register reads back what was written
    a_size_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_IMAGE_SIZE)
        |=> pwrite || (paddr[APB_AW-1] != REG_IMAGE_SIZE)
            || (prdata[10:0] == $past(pwdata[10:0])))
        else $error("image_size readback mismatch");

endmodule

bind box_smooth_3x3_clamped bsc_checker u_bsc_checker (.*);

`default_nettype wire

@@ tb/sv/box_smooth_3x3_clamped_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_smooth_3x3_clamped_tb
// Self-checking bench for the streaming 3x3 clamped box mean filter.
// ----------------------------------------------------------------------------
// Pixel and drain beats are driven on the input stream while a behavioral
// copy of the filter, with its own row stores, window and counters, works out
// every smoothed pixel. A monitor compares each output beat with the oldest
// predicted one. Directed tests cover the reset size, size saturation, full
// scale sums, ignored beats and register writes and large images; random
// frames of mixed sizes, with noise and cut frames, follow. Both stream sides
// stall at random.
// ----------------------------------------------------------------------------

module box_smooth_3x3_clamped_tb
    import bsc_pkg::*;
();

    localparam int LIMIT     = 40000;
    localparam int IDLE_GAP  = 12;
    localparam int MAX_SHOWN = 10;
    localparam int RAND_ITEMS = 300;

    localparam logic [APB_AW-1:0] ADDR_IMAGE_SIZE = APB_AW'(0);
    localparam logic [APB_AW-1:0] ADDR_UNUSED     = APB_AW'(4);

    typedef logic [NCH-1:0][31:0] acc_t;

    typedef struct {
        pix_t px;
        logic last;
    } smoothed_t;

    // dut ports
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;     // in_red[15:0], in_green[31:16], in_blue[47:32]
    logic              s_tuser = 1'b0;   // opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;          // out_red[15:0], out_green[31:16], out_blue[47:32]
    logic              m_tlast;          // frame_end
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // filter copy: configuration, row stores, window and position
    logic [SIZE_W-1:0] size_reg;
    pix_t              upper_row [MAX_DIM];
    pix_t              middle_row [MAX_DIM];
    pix_t              win_col [6];
    int unsigned       row_idx;
    int unsigned       col_idx;
    int unsigned       drain_idx;
    logic              in_drain;

    smoothed_t         mean_q [$];
    int                errors = 0;
    int                cycles = 0;
    logic              calm = 1'b0;

    box_smooth_3x3_clamped dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stall the result side at random
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 15);
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("mismatch %0s: expected %h, actual %h at cycle %0d",
                     what, want, got, cycles);
    endtask

    // compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        smoothed_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_q.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0, {15'd0, m_tlast, m_tdata});
            end else begin
                head = mean_q.pop_front();
                if (m_tdata[15:0] !== head.px[0])
                    report_mismatch("out_red", head.px[0], m_tdata[15:0]);
                if (m_tdata[31:16] !== head.px[1])
                    report_mismatch("out_green", head.px[1], m_tdata[31:16]);
                if (m_tdata[47:32] !== head.px[2])
                    report_mismatch("out_blue", head.px[2], m_tdata[47:32]);
                if (m_tlast !== head.last)
                    report_mismatch("frame_end", head.last, m_tlast);
            end
        end
    end

    function automatic int unsigned frame_dim();
        if (size_reg < SIZE_MIN) return 2;
        if (size_reg > SIZE_MAX) return MAX_DIM;
        return size_reg;
    endfunction

    function automatic acc_t add_px(input acc_t s, input pix_t p);
        for (int j = 0; j < NCH; j++) s[j] = s[j] + p[j];
        return s;
    endfunction

    task automatic restart_frame();
        row_idx   = 0;
        col_idx   = 0;
        drain_idx = 0;
        in_drain  = 1'b0;
    endtask

    task automatic push_mean(input acc_t s, input int unsigned cnt, input logic last);
        smoothed_t r;
        for (int j = 0; j < NCH; j++) r.px[j] = CH_W'(s[j] / cnt);
        r.last = last;
        mean_q.push_back(r);
    endtask

    // advance the filter copy by one accepted beat
    task automatic box_mean_step(input op_t op, input pix_t p);
        int unsigned n, r, c, rows, cols, d, lo, hi;
        pix_t        top, mid;
        acc_t        scur, s1, s2, s;
        n = frame_dim();
        if (op == OP_PUSH) begin
            if (in_drain) return;
            r = (row_idx >= n) ? n - 1 : row_idx;
            c = (col_idx >= n) ? n - 1 : col_idx;
            top = upper_row[c];
            mid = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = p;
            if (r >= 1) begin
                rows = (r >= 2) ? 3 : 2;
                scur = add_px(add_px('0, mid), p);
                s1   = add_px(add_px('0, win_col[1]), win_col[2]);
                s2   = add_px(add_px('0, win_col[4]), win_col[5]);
                if (r >= 2) begin
                    scur = add_px(scur, top);
                    s1   = add_px(s1, win_col[0]);
                    s2   = add_px(s2, win_col[3]);
                end
                if (c >= 1) begin
                    cols = (c >= 2) ? 3 : 2;
                    for (int j = 0; j < NCH; j++)
                        s[j] = scur[j] + s1[j] + ((c >= 2) ? s2[j] : 0);
                    push_mean(s, rows * cols, 1'b0);
                end
                // last column also yields the result centred on its own column
                if (c == n - 1) begin
                    for (int j = 0; j < NCH; j++) s[j] = scur[j] + s1[j];
                    push_mean(s, rows * 2, 1'b0);
                end
            end
            win_col[3] = win_col[0];
            win_col[4] = win_col[1];
            win_col[5] = win_col[2];
            win_col[0] = top;
            win_col[1] = mid;
            win_col[2] = p;
            if (c + 1 >= n) begin
                col_idx = 0;
                if (r + 1 >= n) begin
                    row_idx   = 0;
                    drain_idx = 0;
                    in_drain  = 1'b1;
                end else begin
                    row_idx = r + 1;
                end
            end else begin
                col_idx = c + 1;
            end
        end else begin
            if (!in_drain) return;
            d  = (drain_idx >= n) ? n - 1 : drain_idx;
            lo = (d >= 1) ? d - 1 : 0;
            hi = (d + 1 < n) ? d + 1 : n - 1;
            s  = '0;
            for (int unsigned x = lo; x <= hi; x++)
                s = add_px(add_px(s, upper_row[x]), middle_row[x]);
            push_mean(s, 2 * (hi - lo + 1), d == n - 1);
            if (d == n - 1) restart_frame();
            else drain_idx = d + 1;
        end
    endtask

    function automatic pix_t rand_pix();
        pix_t p;
        for (int j = 0; j < NCH; j++) begin
            case ($urandom_range(7))
                0:       p[j] = '0;
                1:       p[j] = '1;
                default: p[j] = CH_W'($urandom_range(65535));
            endcase
        end
        return p;
    endfunction

    // send one beat; entered and left at a falling edge
    task automatic send_beat(input op_t op, input pix_t p);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = p;
        do @(posedge aclk); while (!s_tready);
        box_mean_step(op, p);
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 9) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
    endtask

    // hold the input until every predicted beat is out, then let the pipe empty
    task automatic wait_results(input int extra);
        s_tvalid = 1'b0;
        while (mean_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[APB_AW-1] == REG_IMAGE_SIZE) begin
            size_reg = data[SIZE_W-1:0];
            restart_frame();
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_size_reg();
        logic [31:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_IMAGE_SIZE;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (got[SIZE_W-1:0] !== size_reg)
            report_mismatch("image_size read", size_reg, got[SIZE_W-1:0]);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_size(input int unsigned value);
        wait_results(IDLE_GAP);
        apb_write(ADDR_IMAGE_SIZE, value);
        check_size_reg();
    endtask

    // push a whole frame of random pixels, then drain it
    task automatic run_frame(input int unsigned n);
        for (int k = 0; k < n * n; k++) send_beat(OP_PUSH, rand_pix());
        for (int k = 0; k < n; k++) send_beat(OP_DRAIN, rand_pix());
    endtask

    // reset size of 32: two rows reach the right border
    task automatic test_reset_size();
        check_size_reg();
        for (int k = 0; k < 64; k++) send_beat(OP_PUSH, rand_pix());
    endtask

    // sizes 0 and 1 saturate to 2; drain before pixels and push while draining
    task automatic test_size_floor();
        set_size(0);
        send_beat(OP_DRAIN, '1);
        send_beat(OP_PUSH, '1);
        send_beat(OP_PUSH, '0);
        send_beat(OP_PUSH, {16'h0000, 16'hFFFF, 16'h0000});
        send_beat(OP_PUSH, {16'hFFFF, 16'h0000, 16'hFFFF});
        send_beat(OP_PUSH, '1);
        send_beat(OP_DRAIN, '0);
        send_beat(OP_PUSH, '1);
        send_beat(OP_DRAIN, '0);
        set_size(1);
        run_frame(2);
    endtask

    // all-ones pixels give the widest sums; second frame runs back to back
    task automatic test_full_scale();
        set_size(3);
        for (int k = 0; k < 9; k++) send_beat(OP_PUSH, '1);
        for (int k = 0; k < 3; k++) send_beat(OP_DRAIN, '1);
        for (int k = 0; k < 9; k++) send_beat(OP_PUSH, (k % 2) ? '1 : '0);
        for (int k = 0; k < 3; k++) send_beat(OP_DRAIN, '0);
    endtask

    // a write to an unused register index leaves the size alone
    task automatic test_unused_register();
        wait_results(IDLE_GAP);
        apb_write(ADDR_UNUSED, 32'd7);
        check_size_reg();
        run_frame(3);
    endtask

    // largest size, reached by saturation; the first row and a few pixels past it
    task automatic test_large_rows();
        set_size(2047);
        for (int k = 0; k < MAX_DIM + 4; k++) send_beat(OP_PUSH, rand_pix());
    endtask

    // random frames with noise beats and frames cut short by a size write
    task automatic test_random_frames();
        int          sent;
        int          frame;
        int unsigned n, total, cut, value;
        sent  = 0;
        frame = 0;
        while (sent < RAND_ITEMS) begin
            if (frame % 11 == 5) begin
                value = $urandom_range(1);
            end else if (frame % 7 == 6) begin
                value = $urandom_range(11, 14);
            end else begin
                value = $urandom_range(2, 10);
            end
            set_size(value);
            n     = frame_dim();
            calm  = (frame == 3 || frame == 4);
            total = n * n + n;
            cut   = ($urandom_range(99) < 8) ? $urandom_range(1, total - 1) : total;
            for (int unsigned k = 0; k < cut; k++) begin
                if (k < n * n) begin
                    if ($urandom_range(99) < 4) send_beat(OP_DRAIN, rand_pix());
                    send_beat(OP_PUSH, rand_pix());
                end else begin
                    // hold off once until the frame body is fully out
                    if (k == n * n && frame == 2) wait_results(0);
                    if ($urandom_range(99) < 4) send_beat(OP_PUSH, rand_pix());
                    send_beat(OP_DRAIN, rand_pix());
                end
                sent++;
            end
            frame++;
        end
        calm = 1'b0;
    endtask

    initial begin
        size_reg = SIZE_RESET;
        for (int k = 0; k < 6; k++) win_col[k] = '0;
        restart_frame();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_size();
        test_size_floor();
        test_full_scale();
        test_unused_register();
        test_large_rows();
        test_random_frames();

        wait_results(IDLE_GAP);
        if (mean_q.size() != 0) report_mismatch("leftover beats", 64'd0, mean_q.size());
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bsc_pkg.sv
rtl/bsc_ctrl.sv
rtl/bsc_sum.sv
rtl/bsc_div.sv
rtl/bsc_fifo.sv
rtl/box_smooth_3x3_clamped.sv
rtl/bsc_checker.sv
tb/sv/box_smooth_3x3_clamped_tb.sv
